FILE: src/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: src/vwd_pkg.sv
// shared constants and controller/datapath interface types for the vertex welder
package vwd_pkg;
    localparam int MAX_VERTICES = 4096;
    localparam int IDX_W = $clog2(MAX_VERTICES);
    localparam int CNT_W = IDX_W + 1;
    localparam int OUT_W = 12;
    localparam int COORD_W = 32;

    typedef struct packed {
        logic load;
        logic issue;
        logic flush;
        logic take_hit;
        logic append;
        logic map_wr;
        logic map_rd;
        logic map_take;
        logic respond;
    } t_cmd;

    typedef struct packed {
        logic more;
        logic hit;
        logic pipe_empty;
        logic in_range;
        logic out_free;
    } t_status;
endpackage

FILE: src/vwd_ram.sv
// generic simple dual-port ram with registered read
module vwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/vwd_ctrl.sv
// controller state machine sequencing scan, append, map update, map lookup and response
module vwd_ctrl import vwd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_mode,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_APPEND, S_MAPWR, S_MAPRD, S_MAPWAIT, S_RESP
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_mode ? S_MAPRD : S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = i_status.more && !i_status.hit;
                if (i_status.hit) begin
                    o_cmd.flush    = 1'b1;
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_MAPWR;
                end else if (!i_status.more && i_status.pipe_empty) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_MAPWR;
            end
            S_MAPWR: begin
                o_cmd.map_wr = 1'b1;
                n_state      = S_RESP;
            end
            S_MAPRD: begin
                o_cmd.map_rd = 1'b1;
                n_state      = i_status.in_range ? S_MAPWAIT : S_RESP;
            end
            S_MAPWAIT: begin
                o_cmd.map_take = 1'b1;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

FILE: src/vwd_datapath.sv
// datapath: unique store, distance pipeline, counters, vertex map and result register
module vwd_datapath import vwd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic [31:0]        i_eps,
    input  logic               i_start_mesh,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [COORD_W-1:0] i_pos_z,
    input  logic [31:0]        i_source_index,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [OUT_W-1:0]   o_remapped_index,
    output logic               o_is_new_vertex,
    output logic               o_index_missing,
    output logic               o_store_full
);
    localparam int UW = 3 * COORD_W;

    logic [COORD_W-1:0] r_px, r_py, r_pz;
    logic [31:0]        r_src;
    logic [CNT_W-1:0]   r_seen, r_total, r_addr;
    logic [IDX_W-1:0]   r_res;
    logic               r_new, r_missing, r_full, r_stored;
    logic [63:0]        r_eps2;

    logic               r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]   r_idx1, r_idx2, r_idx3;
    logic [31:0]        r_ax, r_ay, r_az;
    logic [63:0]        r_sx, r_sy, r_sz;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_idx;
    logic               r_out_new, r_out_missing, r_out_full;

    logic [UW-1:0]      u_rdata;
    logic [IDX_W:0]     m_rdata;
    logic               u_we, m_we;
    logic               room, seen_room;
    logic [65:0]        sq_sum;
    logic               hit;

    function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

    assign room      = (r_total < CNT_W'(MAX_VERTICES));
    assign seen_room = (r_seen < CNT_W'(MAX_VERTICES));
    assign u_we      = i_cmd.append && room;
    assign m_we      = i_cmd.map_wr && seen_room;
    assign sq_sum    = {2'b00, r_sx} + {2'b00, r_sy} + {2'b00, r_sz};
    assign hit       = r_v3 && (sq_sum <= {2'b00, r_eps2});

    vwd_ram #(.WIDTH(UW), .DEPTH(MAX_VERTICES)) u_unique (
        .i_clk   (i_clk),
        .i_we    (u_we),
        .i_waddr (r_total[IDX_W-1:0]),
        .i_wdata ({r_px, r_py, r_pz}),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (u_rdata)
    );

    vwd_ram #(.WIDTH(IDX_W + 1), .DEPTH(MAX_VERTICES)) u_map (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (r_seen[IDX_W-1:0]),
        .i_wdata ({r_stored, r_res}),
        .i_raddr (r_src[IDX_W-1:0]),
        .o_rdata (m_rdata)
    );

    always_ff @(posedge i_clk) begin
        r_eps2 <= 64'(i_eps) * 64'(i_eps);
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_ax   <= abs_diff(u_rdata[UW-1 -: COORD_W], r_px);
        r_ay   <= abs_diff(u_rdata[2*COORD_W-1 -: COORD_W], r_py);
        r_az   <= abs_diff(u_rdata[COORD_W-1:0], r_pz);
        r_sx   <= 64'(r_ax) * 64'(r_ax);
        r_sy   <= 64'(r_ay) * 64'(r_ay);
        r_sz   <= 64'(r_az) * 64'(r_az);
        if (i_cmd.issue) begin
            r_idx1 <= r_addr[IDX_W-1:0];
        end
        if (i_cmd.load) begin
            r_px      <= i_pos_x;
            r_py      <= i_pos_y;
            r_pz      <= i_pos_z;
            r_src     <= i_source_index;
            r_res     <= '0;
            r_new     <= 1'b0;
            r_missing <= 1'b0;
            r_full    <= 1'b0;
            r_stored  <= 1'b1;
        end
        if (i_cmd.take_hit) begin
            r_res <= r_idx3;
        end
        if (i_cmd.append) begin
            if (room) begin
                r_res <= r_total[IDX_W-1:0];
                r_new <= 1'b1;
            end else begin
                r_res    <= '0;
                r_full   <= 1'b1;
                r_stored <= 1'b0;
            end
        end
        if (i_cmd.map_rd && !o_status.in_range) begin
            r_missing <= 1'b1;
        end
        if (i_cmd.map_take) begin
            if (m_rdata[IDX_W]) begin
                r_res <= m_rdata[IDX_W-1:0];
            end else begin
                r_missing <= 1'b1;
            end
        end
        if (i_cmd.respond) begin
            r_out_idx     <= OUT_W'(r_res);
            r_out_new     <= r_new;
            r_out_missing <= r_missing;
            r_out_full    <= r_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen      <= '0;
            r_total     <= '0;
            r_addr      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_addr <= '0;
                if (i_start_mesh) begin
                    r_seen  <= '0;
                    r_total <= '0;
                end
            end
            if (i_cmd.issue) begin
                r_addr <= r_addr + 1'b1;
            end
            if (i_cmd.flush) begin
                r_v1 <= 1'b0;
                r_v2 <= 1'b0;
                r_v3 <= 1'b0;
            end else begin
                r_v1 <= i_cmd.issue;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
            if (u_we) begin
                r_total <= r_total + 1'b1;
            end
            if (m_we) begin
                r_seen <= r_seen + 1'b1;
            end
            if (i_cmd.respond) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.more       = (r_addr < r_total);
    assign o_status.hit        = hit;
    assign o_status.pipe_empty = !r_v1 && !r_v2 && !r_v3;
    assign o_status.in_range   = ({{(32 - CNT_W){1'b0}}, r_seen} > r_src);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_remapped_index = r_out_idx;
    assign o_is_new_vertex  = r_out_new;
    assign o_index_missing  = r_out_missing;
    assign o_store_full     = r_out_full;
endmodule

FILE: src/vertex_weld_dedupe.sv
// top level of the epsilon vertex welder: config port, controller and datapath
// A position transaction scans the stored unique vertices in order, one compare per cycle
// through a read/difference/square/sum pipeline on the unique-position memory, so its
// length grows with N, the number of uniques stored so far (up to 4096), and a match
// with a stored unique ends the scan early. An index transaction reads the vertex map
// memory, and skips the read when the index is beyond the loaded vertices. One
// transaction is worked at a time; a finished result waits in the output register while
// the next transaction is accepted.
// start_mesh clears the mesh by resetting fill counts, so no clearing pass is needed.
`include "assert_macros.svh"
module vertex_weld_dedupe import vwd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic               i_start_mesh,
    input  logic [31:0]        i_pos_x,
    input  logic [31:0]        i_pos_y,
    input  logic [31:0]        i_pos_z,
    input  logic [31:0]        i_source_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [OUT_W-1:0]   o_remapped_index,
    output logic               o_is_new_vertex,
    output logic               o_index_missing,
    output logic               o_store_full
);
    localparam logic REG_EPSILON = 1'b0;

    logic [31:0] r_eps;
    logic        busy;
    t_cmd        cmd;
    t_status     status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_EPSILON)) begin
            r_eps <= pwdata;
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_EPSILON) ? r_eps : '0;
    assign o_in_stall = busy;

    vwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    vwd_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_eps            (r_eps),
        .i_start_mesh     (i_start_mesh),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_pos_z          (i_pos_z),
        .i_source_index   (i_source_index),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_remapped_index (o_remapped_index),
        .o_is_new_vertex  (o_is_new_vertex),
        .o_index_missing  (o_index_missing),
        .o_store_full     (o_store_full)
    );

    `ASSERT_IMPLY(a_resp_free, i_clk, i_rst_n, cmd.respond |-> status.out_free)
    `ASSERT_IMPLY(a_idle_drained, i_clk, i_rst_n, !busy |-> status.pipe_empty)
    `ASSERT_NEVER(a_new_flags, i_clk, i_rst_n, o_out_valid && o_is_new_vertex && (o_store_full || o_index_missing))
    `ASSERT_IMPLY(a_hit_scan, i_clk, i_rst_n, status.hit |-> busy && !status.pipe_empty)
endmodule
